// ===== sv/lbs_pkg.sv =====
// Package for the LED blink slot controller.
// Holds the slot table types, the opcode, level and rate codes, and the blink pattern function.
// No dependencies.
package lbs_pkg;

	localparam int SLOT_COUNT = 15;
	localparam int IDX_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int SLOT_NUM_W = 7;
	localparam int PHASE_COUNT = 6;

	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_START = 2'd1;
	localparam logic [1:0] OP_STOP  = 2'd2;
	localparam logic [1:0] OP_EDIT  = 2'd3;

	localparam logic [2:0] LEVEL_NONE   = 3'd0;
	localparam logic [2:0] LEVEL_GREEN  = 3'd1;
	localparam logic [2:0] LEVEL_YELLOW = 3'd2;
	localparam logic [2:0] LEVEL_RED    = 3'd3;
	localparam logic [2:0] LEVEL_GUN    = 3'd4;

	localparam logic [2:0] RATE_NONE      = 3'd0;
	localparam logic [2:0] RATE_SOLID     = 3'd1;
	localparam logic [2:0] RATE_SLOW      = 3'd2;
	localparam logic [2:0] RATE_MEDIUM    = 3'd3;
	localparam logic [2:0] RATE_FAST      = 3'd4;
	localparam logic [2:0] RATE_IRREGULAR = 3'd5;

	// The gun LED is not switched off when its slot is stopped.
	localparam logic [3:0] LED_STOP_MASK = 4'b0111;

	typedef struct packed {
		logic [2:0] level;
		logic [2:0] rate;
	} slot_entry_t;

	typedef struct packed {
		logic       assigned;
		logic       free;
		logic [3:0] led_bit;
		logic       lit;
	} slot_eval_t;

	function automatic logic pattern_on(input logic [2:0] rate, input logic [2:0] phase);
		logic on;
		on = 1'b0;
		if (rate == RATE_SOLID) on = 1'b1;
		if (phase == 3'd0) on = 1'b1;
		if (phase == 3'd2 && (rate == RATE_FAST || rate == RATE_IRREGULAR)) on = 1'b1;
		if (phase == 3'd3 && rate == RATE_MEDIUM) on = 1'b1;
		if (phase == 3'd4 && rate == RATE_FAST) on = 1'b1;
		return on;
	endfunction

endpackage

// ===== sv/lbs_slot_table.sv =====
// Slot table of the LED blink slot controller: one read port, one write port.
// Entries reset to unassigned. Depends on lbs_pkg.
module lbs_slot_table
	import lbs_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic [IDX_W-1:0]  rd_addr,
	output slot_entry_t       rd_entry,
	input  logic              wr_en,
	input  logic [IDX_W-1:0]  wr_addr,
	input  slot_entry_t       wr_entry
);

	slot_entry_t entries_q [SLOT_COUNT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOT_COUNT; i++) begin
				entries_q[i] <= '0;
			end
		end else if (wr_en) begin
			entries_q[wr_addr] <= wr_entry;
		end
	end

	assign rd_entry = entries_q[rd_addr];

endmodule

// ===== sv/lbs_slot_eval.sv =====
// Shared evaluation unit: classifies one slot entry and decides its LED value for a phase.
// Used once per cycle by the sequencer. Depends on lbs_pkg.
module lbs_slot_eval
	import lbs_pkg::*;
(
	input  slot_entry_t entry,
	input  logic [2:0]  phase,
	output slot_eval_t  result
);

	always_comb begin
		result.assigned = (entry.level != LEVEL_NONE) && (entry.rate != RATE_NONE);
		result.free     = (entry.level == LEVEL_NONE) && (entry.rate == RATE_NONE);
		// Level codes above the gun LED drive nothing.
		unique case (entry.level)
			LEVEL_GREEN:  result.led_bit = 4'b0001;
			LEVEL_YELLOW: result.led_bit = 4'b0010;
			LEVEL_RED:    result.led_bit = 4'b0100;
			LEVEL_GUN:    result.led_bit = 4'b1000;
			default:      result.led_bit = 4'b0000;
		endcase
		if (!result.assigned) result.led_bit = 4'b0000;
		result.lit = pattern_on(entry.rate, phase);
	end

endmodule

// ===== sv/led_blink_slot_controller.sv =====
// Top level of the LED blink slot controller: command sequencer and result register.
// Instantiates lbs_slot_table and lbs_slot_eval. Depends on lbs_pkg.
//
// Usage: commands arrive on the slave stream (s_tvalid, s_tready, s_tdata, s_tuser);
// the opcode travels in s_tuser and the slot, level and rate in s_tdata. Every
// command produces exactly one result transfer on the master stream (m_tvalid,
// m_tready, m_tdata) carrying the LED drive, the slot chosen by a start, and ok.
// A tick walks every slot once, lowest first, through the shared evaluation unit,
// so the lowest-numbered active slot of each LED decides it; the result is loaded
// after the walk has passed the last slot. A start walks the slots from the highest
// down and stops at the first free one. The walks go through the table's single
// read port, one entry per cycle.
// The block takes one command at a time: s_tready is high only while the
// sequencer is idle. The result register lets a new command be taken while the
// previous result still waits; if the receiver stalls, the finished command waits
// until the result register frees up, and no result is ever dropped.
// Reset clears the slot table to unassigned, the phase to the first phase and
// all LEDs to off; there is no clearing pass.
module led_blink_slot_controller
	import lbs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // slot [3:0], level [6:4], rate [9:7], zero [15:10]
	input  logic [1:0]  s_tuser,   // opcode [1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata    // leds [3:0], slot_out [7:4], ok [8], zero [15:9]
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_TICK  = 3'd1;
	localparam logic [2:0] ST_START = 3'd2;
	localparam logic [2:0] ST_STOP  = 3'd3;
	localparam logic [2:0] ST_EDIT  = 3'd4;
	localparam logic [2:0] ST_DONE  = 3'd5;

	logic [2:0]       state_q;
	logic [IDX_W-1:0] idx_q;
	logic [2:0]       phase_q;
	logic [3:0]       led_drive_q;
	logic [3:0]       decided_q;
	logic             m_tvalid_q;

	// Command fields and per-command result, held while the command is worked on.
	logic [3:0]       slot_q;
	slot_entry_t      cmd_entry_q;
	logic [3:0]       res_slot_q;
	logic             res_ok_q;
	logic [3:0]       out_leds_q;
	logic [3:0]       out_slot_q;
	logic             out_ok_q;

	logic [IDX_W-1:0] rd_addr;
	slot_entry_t      rd_entry;
	logic             wr_en;
	slot_entry_t      wr_entry;
	slot_eval_t       ev;
	logic             in_range;
	logic             s_xfer;
	logic             out_load;
	logic [3:0]       new_bits;

	assign s_tready = (state_q == ST_IDLE);
	assign s_xfer   = s_tvalid && s_tready;
	assign out_load = (state_q == ST_DONE) && (!m_tvalid_q || m_tready);
	assign in_range = (SLOT_NUM_W'(slot_q) < SLOT_NUM_W'(SLOT_COUNT));
	assign new_bits = ev.led_bit & ~decided_q;

	// Stop and edit address the commanded slot; tick and start walk the scan index.
	assign rd_addr = (state_q == ST_STOP || state_q == ST_EDIT) ? IDX_W'(slot_q) : idx_q;

	always_comb begin
		wr_en    = 1'b0;
		wr_entry = cmd_entry_q;
		unique case (state_q)
			ST_START: wr_en = ev.free;
			ST_STOP: begin
				wr_en    = in_range && ev.assigned;
				wr_entry = '0;
			end
			ST_EDIT: wr_en = in_range;
			default: wr_en = 1'b0;
		endcase
	end

	lbs_slot_table u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_addr  (rd_addr),
		.rd_entry (rd_entry),
		.wr_en    (wr_en),
		.wr_addr  (rd_addr),
		.wr_entry (wr_entry)
	);

	lbs_slot_eval u_eval (
		.entry  (rd_entry),
		.phase  (phase_q),
		.result (ev)
	);

	// Sequencer and LED state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			phase_q     <= '0;
			led_drive_q <= '0;
			decided_q   <= '0;
			m_tvalid_q  <= 1'b0;
		end else begin
			// A new result takes the register as the old one leaves it.
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_xfer) begin
						decided_q <= '0;
						unique case (s_tuser)
							OP_TICK: begin
								idx_q   <= '0;
								state_q <= ST_TICK;
							end
							OP_START: begin
								idx_q   <= IDX_W'(SLOT_COUNT - 1);
								state_q <= ST_START;
							end
							OP_STOP: state_q <= ST_STOP;
							default: state_q <= ST_EDIT;
						endcase
					end
				end
				ST_TICK: begin
					// The first active slot seen for an LED decides it.
					decided_q   <= decided_q | new_bits;
					led_drive_q <= ev.lit ? (led_drive_q | new_bits)
					                      : (led_drive_q & ~new_bits);
					if (idx_q == IDX_W'(SLOT_COUNT - 1)) begin
						phase_q <= (phase_q >= 3'(PHASE_COUNT - 1)) ? 3'd0 : phase_q + 3'd1;
						state_q <= ST_DONE;
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				ST_START: begin
					if (ev.free || idx_q == '0) begin
						state_q <= ST_DONE;
					end else begin
						idx_q <= idx_q - IDX_W'(1);
					end
				end
				ST_STOP: begin
					if (in_range && ev.assigned) begin
						led_drive_q <= led_drive_q & ~(ev.led_bit & LED_STOP_MASK);
					end
					state_q <= ST_DONE;
				end
				ST_EDIT: state_q <= ST_DONE;
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Command fields and result payload carry no reset.
	always_ff @(posedge clk) begin
		if (s_xfer) begin
			slot_q            <= s_tdata[3:0];
			cmd_entry_q.level <= s_tdata[6:4];
			cmd_entry_q.rate  <= s_tdata[9:7];
			res_slot_q        <= '0;
			res_ok_q          <= 1'b0;
		end
		if (state_q == ST_START && ev.free) begin
			res_slot_q <= 4'(idx_q);
			res_ok_q   <= 1'b1;
		end
		if (state_q == ST_STOP && in_range && ev.assigned) begin
			res_ok_q <= 1'b1;
		end
		if (out_load) begin
			out_leds_q <= led_drive_q;
			out_slot_q <= res_slot_q;
			out_ok_q   <= res_ok_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {7'b0, out_ok_q, out_slot_q, out_leds_q};

	// The phase counter never leaves its six phases.
	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q < 3'(PHASE_COUNT))
		else $error("phase counter out of range");

	// The scan index stays inside the table.
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		SLOT_NUM_W'(idx_q) < SLOT_NUM_W'(SLOT_COUNT))
		else $error("scan index out of range");

	// A nonzero slot in a result only comes from a successful start.
	a_slot_needs_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && out_slot_q != 4'd0) |-> out_ok_q)
		else $error("result slot set without ok");

	// A result is loaded only when a command has finished.
	a_load_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(state_q) == ST_DONE)
		else $error("result loaded outside done state");

endmodule

// ===== tb/sv/lbs_status_checker.sv =====
// Checker for the LED blink slot controller: watches both streams, predicts each status result.
// Keeps its own copy of the slot table, blink phase and LED drive, and compares every transfer.
// Depends on lbs_pkg for the opcode, level and rate codes.
module lbs_status_checker
	import lbs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [15:0] s_tdata,   // slot [3:0], level [6:4], rate [9:7], zero [15:10]
	input  logic [1:0]  s_tuser,   // opcode [1:0]
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [15:0] m_tdata,   // leds [3:0], slot_out [7:4], ok [8], zero [15:9]
	output int          fail_count,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_PRINTED = 50;

	typedef struct packed {
		logic [3:0] leds;
		logic [3:0] slot_out;
		logic       ok;
	} led_status_t;

	logic [2:0]  tbl_level [SLOT_COUNT];
	logic [2:0]  tbl_rate  [SLOT_COUNT];
	logic [2:0]  blink_phase;
	logic [3:0]  led_state;
	led_status_t status_q [$];
	int          result_index;

	function automatic logic blink_lit(input logic [2:0] rate, input logic [2:0] ph);
		case (ph)
		3'd0: return 1'b1;
		3'd2: return rate == RATE_SOLID || rate == RATE_FAST || rate == RATE_IRREGULAR;
		3'd3: return rate == RATE_SOLID || rate == RATE_MEDIUM;
		3'd4: return rate == RATE_SOLID || rate == RATE_FAST;
		default: return rate == RATE_SOLID;
		endcase
	endfunction

	task automatic report_mismatch(input string msg);
		fail_count = fail_count + 1;
		if (fail_count <= MAX_PRINTED)
			$display("mismatch at result %0d: %s", result_index, msg);
	endtask

	// Applies one command to the shadow state and returns the status it should produce.
	task automatic predict_status(input logic [1:0] op, input logic [3:0] sl,
			input logic [2:0] lv, input logic [2:0] rt, output led_status_t res);
		logic [3:0] decided;
		logic [3:0] drive;
		logic [3:0] bit_mask;
		logic       found;
		res = '0;
		case (op)
		OP_TICK: begin
			decided = '0;
			drive = led_state;
			for (int i = 0; i < SLOT_COUNT; i++) begin
				if (tbl_level[i] != LEVEL_NONE && tbl_rate[i] != RATE_NONE &&
						tbl_level[i] <= LEVEL_GUN) begin
					bit_mask = 4'b0001 << (tbl_level[i] - 3'd1);
					if ((decided & bit_mask) == '0) begin
						decided |= bit_mask;
						if (blink_lit(tbl_rate[i], blink_phase))
							drive |= bit_mask;
						else
							drive &= ~bit_mask;
					end
				end
			end
			led_state = drive;
			blink_phase = (blink_phase >= 3'(PHASE_COUNT - 1)) ? 3'd0 : blink_phase + 3'd1;
		end
		OP_START: begin
			found = 1'b0;
			for (int k = SLOT_COUNT - 1; k >= 0; k--) begin
				if (!found && tbl_level[k] == LEVEL_NONE && tbl_rate[k] == RATE_NONE) begin
					found = 1'b1;
					tbl_level[k] = lv;
					tbl_rate[k] = rt;
					res.slot_out = 4'(k);
					res.ok = 1'b1;
				end
			end
		end
		OP_STOP: begin
			if (sl < SLOT_COUNT && tbl_level[sl] != LEVEL_NONE && tbl_rate[sl] != RATE_NONE) begin
				// The gun LED and the unused level codes leave the drive alone.
				if (tbl_level[sl] >= LEVEL_GREEN && tbl_level[sl] <= LEVEL_RED)
					led_state &= ~(4'b0001 << (tbl_level[sl] - 3'd1));
				tbl_level[sl] = LEVEL_NONE;
				tbl_rate[sl] = RATE_NONE;
				res.ok = 1'b1;
			end
		end
		default: begin
			if (sl < SLOT_COUNT) begin
				tbl_level[sl] = lv;
				tbl_rate[sl] = rt;
			end
		end
		endcase
		res.leds = led_state;
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		led_status_t want;
		led_status_t got;
		if (!arst_n) begin
			for (int i = 0; i < SLOT_COUNT; i++) begin
				tbl_level[i] = LEVEL_NONE;
				tbl_rate[i] = RATE_NONE;
			end
			blink_phase = '0;
			led_state = '0;
			status_q.delete();
			result_index = 0;
			fail_count = 0;
			pending <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				predict_status(s_tuser, s_tdata[3:0], s_tdata[6:4], s_tdata[9:7], want);
				status_q.push_back(want);
			end
			if (m_tvalid && m_tready) begin
				got.leds = m_tdata[3:0];
				got.slot_out = m_tdata[7:4];
				got.ok = m_tdata[8];
				if (status_q.size() == 0) begin
					report_mismatch($sformatf("result %h with nothing expected", m_tdata));
				end else begin
					want = status_q.pop_front();
					if (got.leds !== want.leds)
						report_mismatch($sformatf("leds got %h want %h", got.leds, want.leds));
					if (got.slot_out !== want.slot_out)
						report_mismatch($sformatf("slot_out got %0d want %0d",
							got.slot_out, want.slot_out));
					if (got.ok !== want.ok)
						report_mismatch($sformatf("ok got %b want %b", got.ok, want.ok));
				end
				result_index = result_index + 1;
			end
			pending <= status_q.size();
		end
	end

endmodule

// ===== tb/sv/tb.sv =====
// Top of the LED blink slot controller testbench: clock, reset, command stimulus and verdict.
// Instantiates led_blink_slot_controller and lbs_status_checker; depends on lbs_pkg.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import lbs_pkg::*;

	// Codes that the block accepts but that carry no name in the package.
	localparam logic [2:0] LEVEL_CODE_7 = 3'd7;
	localparam logic [2:0] RATE_CODE_6  = 3'd6;
	localparam logic [2:0] RATE_CODE_7  = 3'd7;
	localparam logic [3:0] SLOT_BEYOND  = 4'd15;

	localparam int PHASE_ITEMS = 482;
	localparam int MODE_SPAN   = 40;
	localparam int HOLD_CYCLES = 400;
	localparam int TAIL_CYCLES = 40;
	localparam int CYCLE_LIMIT = 400000;

	// How the random commands lean: a mix, filling the table, or emptying it.
	typedef enum int {MODE_MIXED, MODE_FILL, MODE_DRAIN} stim_mode_e;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;
	logic [1:0]  s_tuser = OP_TICK;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;

	int fail_count;
	int pending;
	int cycle_count = 0;
	int tx_idle_pct = 0;
	int rx_stall_pct = 0;

	// The long receiver hold-off is requested by the stimulus and counted by the receiver.
	logic hold_req = 1'b0;
	logic hold_taken = 1'b0;
	int   hold_left = 0;

	led_blink_slot_controller dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	lbs_status_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Receiver: stalls at the rate of the current phase. When the hold-off is requested
	// it keeps tready low for a long stretch, once, so that the result register and the
	// finished command behind it both back up and the block drops s_tready.
	always @(posedge clk) begin
		if (hold_req && !hold_taken) begin
			hold_taken <= 1'b1;
			hold_left <= HOLD_CYCLES;
			m_tready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("led_blink_slot_controller regression: fail");
			$finish;
		end
	end

	// Offers one command and returns at the edge where its transfer happens. Idle
	// cycles before it are drawn at the sender's current idle rate.
	task automatic send_cmd(input logic [1:0] op, input logic [3:0] sl,
			input logic [2:0] lv, input logic [2:0] rt);
		while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {6'd0, rt, lv, sl};
		do @(posedge clk); while (!s_tready);
	endtask

	// Stops offering and waits until every predicted status has been received.
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	// Builds one random command. Most are well formed: a real LED level, a real rate and
	// a slot inside the table, with the opcode mix set by the mode. About one in ten is
	// noise over the full width of every field, which reaches the unused level and rate
	// codes and the slot number beyond the table.
	task automatic random_cmd(input stim_mode_e mode, output logic [1:0] op,
			output logic [3:0] sl, output logic [2:0] lv, output logic [2:0] rt);
		int pick;
		int cut_tick;
		int cut_start;
		int cut_stop;
		if ($urandom_range(99) < 10) begin
			op = 2'($urandom_range(3));
			sl = 4'($urandom_range(15));
			lv = 3'($urandom_range(7));
			rt = 3'($urandom_range(7));
		end else begin
			case (mode)
			MODE_FILL: begin
				cut_tick = 30;
				cut_start = 85;
				cut_stop = 90;
			end
			MODE_DRAIN: begin
				cut_tick = 35;
				cut_start = 40;
				cut_stop = 90;
			end
			default: begin
				cut_tick = 45;
				cut_start = 65;
				cut_stop = 85;
			end
			endcase
			pick = $urandom_range(99);
			if (pick < cut_tick)
				op = OP_TICK;
			else if (pick < cut_start)
				op = OP_START;
			else if (pick < cut_stop)
				op = OP_STOP;
			else
				op = OP_EDIT;
			sl = 4'($urandom_range(SLOT_COUNT - 1));
			lv = 3'($urandom_range(LEVEL_GUN, LEVEL_GREEN));
			rt = 3'($urandom_range(RATE_IRREGULAR, RATE_SOLID));
			// Some edits clear a slot, which frees it for the next start.
			if (op == OP_EDIT && $urandom_range(99) < 20) begin
				lv = LEVEL_NONE;
				rt = RATE_NONE;
			end
		end
	endtask

	initial begin : stimulus
		logic [1:0] op;
		logic [3:0] sl;
		logic [2:0] lv;
		logic [2:0] rt;
		stim_mode_e mode;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. A tick on the empty table, stops on a free slot and past the
		// table, and an edit past the table that must be ignored.
		send_cmd(OP_TICK, 4'd0, LEVEL_NONE, RATE_NONE);
		send_cmd(OP_STOP, 4'd3, LEVEL_NONE, RATE_NONE);
		send_cmd(OP_STOP, SLOT_BEYOND, LEVEL_NONE, RATE_NONE);
		send_cmd(OP_EDIT, SLOT_BEYOND, LEVEL_CODE_7, RATE_CODE_7);
		// Starts fill slots from the top down: every LED, every rate, a level code that
		// drives nothing, a rate code that behaves like slow and sits below the red
		// medium slot, and a start with a zero level that leaves a slot neither free
		// nor active.
		send_cmd(OP_START, 4'd0, LEVEL_GREEN, RATE_SOLID);
		send_cmd(OP_START, 4'd0, LEVEL_YELLOW, RATE_FAST);
		send_cmd(OP_START, 4'd0, LEVEL_RED, RATE_MEDIUM);
		send_cmd(OP_START, 4'd0, LEVEL_GUN, RATE_IRREGULAR);
		send_cmd(OP_START, 4'd0, LEVEL_CODE_7, RATE_SLOW);
		send_cmd(OP_START, 4'd0, LEVEL_RED, RATE_CODE_6);
		send_cmd(OP_START, 4'd0, LEVEL_NONE, RATE_MEDIUM);
		// Six ticks walk through every phase and wrap.
		repeat (6) send_cmd(OP_TICK, 4'd0, LEVEL_NONE, RATE_NONE);
		// Stopping the gun slot keeps the gun LED; stopping the slot with the unused
		// level still counts as a hit.
		send_cmd(OP_STOP, 4'd11, LEVEL_NONE, RATE_NONE);
		send_cmd(OP_STOP, 4'd10, LEVEL_NONE, RATE_NONE);
		// Slot 0 now outranks the solid green slot, with a rate code that acts as slow.
		send_cmd(OP_EDIT, 4'd0, LEVEL_GREEN, RATE_CODE_7);
		send_cmd(OP_TICK, 4'd0, LEVEL_NONE, RATE_NONE);
		send_cmd(OP_STOP, 4'd8, LEVEL_NONE, RATE_NONE);
		send_cmd(OP_TICK, 4'd0, LEVEL_NONE, RATE_NONE);
		wait_drained();

		// Random part in four idling phases: none, sender idle, receiver stalling, both.
		// The first phase also carries the long receiver hold-off while the sender keeps
		// offering. Between phases the sender pauses until every result is in.
		mode = MODE_MIXED;
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
			0: begin
				tx_idle_pct = 0;
				rx_stall_pct <= 0;
				hold_req <= 1'b1;
			end
			1: begin
				tx_idle_pct = 55;
				rx_stall_pct <= 0;
			end
			2: begin
				tx_idle_pct = 0;
				rx_stall_pct <= 55;
			end
			default: begin
				tx_idle_pct = 33;
				rx_stall_pct <= 33;
			end
			endcase
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// Stretches of a single mode let the table fill up completely and empty again.
				if (n % MODE_SPAN == 0)
					mode = stim_mode_e'($urandom_range(MODE_DRAIN));
				random_cmd(mode, op, sl, lv, rt);
				send_cmd(op, sl, lv, rt);
			end
			wait_drained();
		end

		// Let any stray result show up before the verdict.
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("led_blink_slot_controller regression: pass");
		else
			$display("led_blink_slot_controller regression: fail");
		$finish;
	end

endmodule
